// File: rtl/eofhp_pkg.sv
// shared types, codes and helper functions for the container header parser
package eofhp_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned MAXC_W   = 11;
    localparam int unsigned MAXS_W   = 9;
    localparam int unsigned REM_W    = 11;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned BODY_W   = 48;

    // result queue geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

    // section count limits
    localparam logic [MAXC_W-1:0] CAP_CODE = MAXC_W'(1024);
    localparam logic [MAXS_W-1:0] CAP_CONT = MAXS_W'(256);

    // configuration register indexes (address bit 2)
    localparam logic REG_MAX_CODE = 1'b0;
    localparam logic REG_MAX_CONT = 1'b1;

    // section id bytes
    localparam logic [BYTE_W-1:0] ID_TERM = 8'h00;
    localparam logic [BYTE_W-1:0] ID_TYPE = 8'h01;
    localparam logic [BYTE_W-1:0] ID_CODE = 8'h02;
    localparam logic [BYTE_W-1:0] ID_CONT = 8'h03;
    localparam logic [BYTE_W-1:0] ID_DATA = 8'hff;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_TYPE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CODE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CONT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TERM      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TYPE      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CODE      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NO_DATA      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_INCOMP_NUM   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_MANY_CODE    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_MANY_CONT    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_INCOMP_SIZE  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_NOT_TERM     = 4'd10;
    localparam logic [STATUS_W-1:0] ST_BAD_BODY     = 4'd11;

    // parse phase
    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_COUNT = 2'd1,
        PH_SIZE  = 2'd2,
        PH_BODY  = 2'd3
    } t_phase;

    // section codes
    typedef enum logic [2:0] {
        SEC_TERM = 3'd0,
        SEC_TYPE = 3'd1,
        SEC_CODE = 3'd2,
        SEC_CONT = 3'd3,
        SEC_DATA = 3'd4,
        SEC_BAD  = 3'd7
    } t_sec;

    // one result record
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  index;
        logic [SIZE_W-1:0]   size;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_rec;

    // map a section id byte to its section code
    function automatic t_sec id_code(input logic [BYTE_W-1:0] b);
        t_sec sec;
        unique case (b)
            ID_TERM: sec = SEC_TERM;
            ID_TYPE: sec = SEC_TYPE;
            ID_CODE: sec = SEC_CODE;
            ID_CONT: sec = SEC_CONT;
            ID_DATA: sec = SEC_DATA;
            default: sec = SEC_BAD;
        endcase
        return sec;
    endfunction

    // status for a section that was expected but did not arrive
    function automatic logic [STATUS_W-1:0] missing_status(input t_sec sec);
        logic [STATUS_W-1:0] st;
        unique case (sec)
            SEC_TERM: st = ST_NO_TERM;
            SEC_TYPE: st = ST_NO_TYPE;
            SEC_CODE: st = ST_NO_CODE;
            default:  st = ST_NO_DATA;
        endcase
        return st;
    endfunction

endpackage

// File: rtl/eof_section_header_parser.sv
// container section header parser: byte stream in, size and status records out
//
// Input channel: one container byte a transfer (i_byte_value, i_last_byte),
// taken when i_in_valid is high and o_in_stall is low. The first byte is the
// one after the magic and version bytes; i_last_byte marks the container end.
// Output channel: records (kind, section index, size, status, last flag),
// taken when o_out_valid is high and i_out_stall is low. Each accepted size
// gives one record; the last byte of a container gives one status record
// with o_last_record set, so a byte causes zero, one or two records.
// A taken byte is held in the input register; its records enter the queue.
// Throughput: one byte per cycle. The byte register hands to a four-entry
// record queue; a byte is processed only while the queue has room for two
// records, so with the receiver taking a record every cycle the input never
// stalls, apart from the one extra record a container end can add.
// While the receiver stalls, the queue fills and then o_in_stall rises.
// Reset clears the parse state, empties the queue and sets the limits to 1024
// code and 256 container sections. Limits are written over the APB port at
// 0x0 (code) and 0x4 (container), by the user only while idle (not enforced).
module eof_section_header_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input byte channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [eofhp_pkg::BYTE_W-1:0]       i_byte_value,
    input  logic                               i_last_byte,
    // record channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [eofhp_pkg::KIND_W-1:0]       o_record_kind,
    output logic [eofhp_pkg::INDEX_W-1:0]      o_section_index,
    output logic [eofhp_pkg::SIZE_W-1:0]       o_sec_length,
    output logic [eofhp_pkg::STATUS_W-1:0]     o_status,
    output logic                               o_last_record,
    // configuration port
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [eofhp_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [eofhp_pkg::PDATA_W-1:0]      i_pwdata,
    output logic [eofhp_pkg::PDATA_W-1:0]      o_prdata,
    output logic                               o_pready
);
    import eofhp_pkg::*;

    // configuration registers
    logic [MAXC_W-1:0] r_max_code;
    logic [MAXS_W-1:0] r_max_cont;
    logic              w_cfg_wr;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              w_in_acc;
    logic              w_adv;

    // parse state
    t_phase             r_phase, step_phase, n_phase;
    t_sec               r_expected, step_expected, n_expected;
    t_sec               r_current, step_current, n_current;
    logic [1:0]         r_fcnt, step_fcnt, n_fcnt;
    logic [SIZE_W-1:0]  r_acc, step_acc, n_acc;
    logic [REM_W-1:0]   r_remaining, step_remaining, n_remaining;
    logic [INDEX_W-1:0] r_index, step_index, n_index;
    logic [DATA_W-1:0]  r_data_size, step_data_size, n_data_size;
    logic [BODY_W-1:0]  r_sum, step_sum, n_sum;
    logic [BODY_W-1:0]  r_body, step_body, n_body;
    logic               r_err, step_err, n_err;

    // decoded byte conditions
    t_sec               w_id_sec;
    t_sec               w_exp;
    logic               w_id_match;
    logic [15:0]        w_cnt_acc;
    logic               w_cnt_done;
    logic               w_is_code;
    logic [MAXC_W-1:0]  w_lim;
    logic               w_cnt_zero;
    logic               w_cnt_over;
    logic [SIZE_W-1:0]  w_sz_acc;
    logic [2:0]         w_sz_cnt;
    logic [2:0]         w_sz_width;
    logic               w_sz_done;
    logic               w_sz_zero_bad;
    logic [REM_W-1:0]   w_rem_dec;
    logic [BODY_W-1:0]  w_body_inc;
    logic [BODY_W:0]    w_body_hi;

    // records produced this cycle
    logic               w_push_size;
    logic               w_push_stat;
    t_rec               w_size_rec;
    t_rec               w_stat_rec;
    logic               w_push0;
    logic               w_push1;
    t_rec               w_rec0;

    // record queue
    t_rec                  r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;
    logic [FIFO_PTR_W-1:0] w_wr_ptr1;
    t_rec                  w_head;

    // apb register access
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code <= CAP_CODE;
            r_max_cont <= CAP_CONT;
        end else if (w_cfg_wr) begin
            unique case (i_paddr[2])
                REG_MAX_CODE: r_max_code <= i_pwdata[MAXC_W-1:0];
                REG_MAX_CONT: r_max_cont <= i_pwdata[MAXS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_MAX_CODE: o_prdata = PDATA_W'(r_max_code);
            REG_MAX_CONT: o_prdata = PDATA_W'(r_max_cont);
            default:      o_prdata = '0;
        endcase
    end

    // input register, advances when the queue has room for two records
    assign w_adv      = r_in_valid && (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
    end

    // section id decode, a skipped container section falls through to data
    assign w_id_sec   = id_code(r_byte);
    assign w_exp      = (w_id_sec != r_expected && r_expected == SEC_CONT) ? SEC_DATA
                                                                           : r_expected;
    assign w_id_match = (w_id_sec == w_exp);

    // section count field
    assign w_cnt_acc  = {r_acc[7:0], r_byte};
    assign w_cnt_done = (r_fcnt == 2'd1);
    assign w_is_code  = (r_current == SEC_CODE);
    always_comb begin
        if (w_is_code) begin
            w_lim = (r_max_code > CAP_CODE) ? CAP_CODE : r_max_code;
        end else begin
            w_lim = MAXC_W'((r_max_cont > CAP_CONT) ? CAP_CONT : r_max_cont);
        end
    end
    assign w_cnt_zero = (w_cnt_acc == '0);
    assign w_cnt_over = (w_cnt_acc > 16'(w_lim));

    // size field, four bytes for container sections and two otherwise
    assign w_sz_acc      = {r_acc[SIZE_W-9:0], r_byte};
    assign w_sz_cnt      = {1'b0, r_fcnt} + 3'd1;
    assign w_sz_width    = (r_current == SEC_CONT) ? 3'd4 : 3'd2;
    assign w_sz_done     = (w_sz_cnt >= w_sz_width);
    assign w_sz_zero_bad = (w_sz_acc == '0) && (r_current != SEC_DATA);
    assign w_rem_dec     = r_remaining - REM_W'(1);

    // saturating body byte counter
    assign w_body_inc = (r_body == '1) ? r_body : r_body + BODY_W'(1);

    // parse state after this byte
    always_comb begin
        step_phase     = r_phase;
        step_expected  = r_expected;
        step_current   = r_current;
        step_fcnt      = r_fcnt;
        step_acc       = r_acc;
        step_remaining = r_remaining;
        step_index     = r_index;
        step_data_size = r_data_size;
        step_sum       = r_sum;
        step_body      = r_body;
        step_err       = r_err;
        if (!r_err) begin
            unique case (r_phase)
                PH_ID: begin
                    step_expected = w_exp;
                    if (!w_id_match) begin
                        step_err = 1'b1;
                        step_acc = SIZE_W'(missing_status(w_exp));
                    end else begin
                        step_current = w_id_sec;
                        step_fcnt    = 2'd0;
                        step_acc     = '0;
                        step_index   = '0;
                        unique case (w_id_sec)
                            SEC_TERM: step_phase = PH_BODY;
                            SEC_TYPE: begin
                                step_expected  = SEC_CODE;
                                step_remaining = REM_W'(1);
                                step_phase     = PH_SIZE;
                            end
                            SEC_DATA: begin
                                step_expected  = SEC_TERM;
                                step_remaining = REM_W'(1);
                                step_phase     = PH_SIZE;
                            end
                            SEC_CODE: begin
                                step_expected = SEC_CONT;
                                step_phase    = PH_COUNT;
                            end
                            default: begin
                                step_expected = SEC_DATA;
                                step_phase    = PH_COUNT;
                            end
                        endcase
                    end
                end
                PH_COUNT: begin
                    step_acc  = SIZE_W'(w_cnt_acc);
                    step_fcnt = r_fcnt + 2'd1;
                    if (w_cnt_done) begin
                        if (w_cnt_zero) begin
                            step_err = 1'b1;
                            step_acc = SIZE_W'(ST_ZERO_SIZE);
                        end else if (w_cnt_over) begin
                            step_err = 1'b1;
                            step_acc = SIZE_W'(w_is_code ? ST_MANY_CODE : ST_MANY_CONT);
                        end else begin
                            step_remaining = w_cnt_acc[REM_W-1:0];
                            step_index     = '0;
                            step_fcnt      = 2'd0;
                            step_acc       = '0;
                            step_phase     = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    step_acc  = w_sz_acc;
                    step_fcnt = w_sz_cnt[1:0];
                    if (w_sz_done) begin
                        if (w_sz_zero_bad) begin
                            step_err = 1'b1;
                            step_acc = SIZE_W'(ST_ZERO_SIZE);
                        end else begin
                            if (r_current == SEC_DATA) begin
                                step_data_size = w_sz_acc[DATA_W-1:0];
                            end else begin
                                step_sum = r_sum + BODY_W'(w_sz_acc);
                            end
                            step_remaining = w_rem_dec;
                            step_index     = r_index + INDEX_W'(1);
                            step_fcnt      = 2'd0;
                            step_acc       = '0;
                            if (w_rem_dec == '0) begin
                                step_index = '0;
                                step_phase = PH_ID;
                            end
                        end
                    end
                end
                default: begin
                    step_body = w_body_inc;
                end
            endcase
        end
    end

    // next state: a container end starts the parse afresh
    always_comb begin
        n_phase     = r_phase;
        n_expected  = r_expected;
        n_current   = r_current;
        n_fcnt      = r_fcnt;
        n_acc       = r_acc;
        n_remaining = r_remaining;
        n_index     = r_index;
        n_data_size = r_data_size;
        n_sum       = r_sum;
        n_body      = r_body;
        n_err       = r_err;
        if (w_adv) begin
            if (r_last) begin
                n_phase     = PH_ID;
                n_expected  = SEC_TYPE;
                n_current   = SEC_TERM;
                n_fcnt      = 2'd0;
                n_acc       = '0;
                n_remaining = '0;
                n_index     = '0;
                n_data_size = '0;
                n_sum       = '0;
                n_body      = '0;
                n_err       = 1'b0;
            end else begin
                n_phase     = step_phase;
                n_expected  = step_expected;
                n_current   = step_current;
                n_fcnt      = step_fcnt;
                n_acc       = step_acc;
                n_remaining = step_remaining;
                n_index     = step_index;
                n_data_size = step_data_size;
                n_sum       = step_sum;
                n_body      = step_body;
                n_err       = step_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_expected  <= SEC_TYPE;
            r_current   <= SEC_TERM;
            r_fcnt      <= 2'd0;
            r_acc       <= '0;
            r_remaining <= '0;
            r_index     <= '0;
            r_data_size <= '0;
            r_sum       <= '0;
            r_body      <= '0;
            r_err       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_expected  <= n_expected;
            r_current   <= n_current;
            r_fcnt      <= n_fcnt;
            r_acc       <= n_acc;
            r_remaining <= n_remaining;
            r_index     <= n_index;
            r_data_size <= n_data_size;
            r_sum       <= n_sum;
            r_body      <= n_body;
            r_err       <= n_err;
        end
    end

    // size record for a completed size, nonzero apart from the data section
    assign w_push_size = w_adv && !r_err && (r_phase == PH_SIZE) && w_sz_done
                         && !w_sz_zero_bad;
    always_comb begin
        w_size_rec        = '0;
        w_size_rec.size   = w_sz_acc;
        unique case (r_current)
            SEC_TYPE: w_size_rec.kind = KIND_TYPE;
            SEC_CODE: begin
                w_size_rec.kind  = KIND_CODE;
                w_size_rec.index = r_index;
            end
            SEC_CONT: begin
                w_size_rec.kind  = KIND_CONT;
                w_size_rec.index = r_index;
            end
            default:  w_size_rec.kind = KIND_DATA;
        endcase
    end

    // status record at the container end
    assign w_push_stat = w_adv && r_last;
    assign w_body_hi   = {1'b0, step_sum} + (BODY_W + 1)'(step_data_size);
    always_comb begin
        w_stat_rec      = '0;
        w_stat_rec.kind = KIND_STATUS;
        w_stat_rec.last = 1'b1;
        if (step_err) begin
            w_stat_rec.status = step_acc[STATUS_W-1:0];
        end else begin
            unique case (step_phase)
                PH_ID:    w_stat_rec.status = ST_NOT_TERM;
                PH_COUNT: w_stat_rec.status = ST_INCOMP_NUM;
                PH_SIZE:  w_stat_rec.status = (step_fcnt != 2'd0 || step_index != '0)
                                              ? ST_INCOMP_SIZE : ST_NOT_TERM;
                default:  w_stat_rec.status = (step_body < step_sum
                                               || {1'b0, step_body} > w_body_hi)
                                              ? ST_BAD_BODY : ST_OK;
            endcase
        end
    end

    // queue writes: size record first, status after it
    assign w_push0   = w_push_size || w_push_stat;
    assign w_push1   = w_push_size && w_push_stat;
    assign w_rec0    = w_push_size ? w_size_rec : w_stat_rec;
    assign w_wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);
    assign w_pop     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            if (w_push0 && r_wr_ptr == FIFO_PTR_W'(i)) begin
                r_fifo[i] <= w_rec0;
            end else if (w_push1 && w_wr_ptr1 == FIFO_PTR_W'(i)) begin
                r_fifo[i] <= w_stat_rec;
            end
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(w_push0) + FIFO_PTR_W'(w_push1);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(w_pop);
            r_count  <= r_count + FIFO_CNT_W'(w_push0) + FIFO_CNT_W'(w_push1)
                        - FIFO_CNT_W'(w_pop);
        end
    end

    // output from the queue head
    assign w_head          = r_fifo[r_rd_ptr];
    assign o_out_valid     = (r_count != '0);
    assign o_record_kind   = w_head.kind;
    assign o_section_index = w_head.index;
    assign o_sec_length    = w_head.size;
    assign o_status        = w_head.status;
    assign o_last_record   = w_head.last;

    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("record queue overflow");

    // a container end leaves the parser in its reset state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_stat |=> (r_phase == PH_ID && !r_err && r_expected == SEC_TYPE
                         && r_body == '0 && r_sum == '0))
        else $error("parse state not cleared after container end");

    // the first error stays until the container ends
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(w_adv && r_last)) |=> r_err)
        else $error("latched error lost before container end");

    // only the final record of a container carries the last flag
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_record == (o_record_kind == KIND_STATUS)))
        else $error("last flag does not match record kind");

    // two records in one cycle only at a container end
    a_two_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push1 |-> (r_last && r_phase == PH_SIZE))
        else $error("double record outside a container end");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the container section header parser
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eofhp_pkg::*;

    localparam int unsigned RUN_LIMIT    = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned SCRIPT_ROWS  = 23;

    localparam logic [PADDR_W-1:0] ADDR_MAX_CODE = {REG_MAX_CODE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MAX_CONT = {REG_MAX_CONT, 2'b00};

    // one row of the directed byte script
    typedef struct packed {
        logic [BYTE_W-1:0]   value;
        logic                fin;
        logic                typed;
        logic [STATUS_W-1:0] status;
    } t_script_row;

    // clock, reset and block ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_byte_value = '0;
    logic                i_last_byte = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [KIND_W-1:0]   o_record_kind;
    logic [INDEX_W-1:0]  o_section_index;
    logic [SIZE_W-1:0]   o_sec_length;
    logic [STATUS_W-1:0] o_status;
    logic                o_last_record;
    logic                i_psel = 1'b0;
    logic                i_penable = 1'b0;
    logic                i_pwrite = 1'b0;
    logic [PADDR_W-1:0]  i_paddr = '0;
    logic [PDATA_W-1:0]  i_pwdata = '0;
    logic [PDATA_W-1:0]  o_prdata;
    logic                o_pready;

    // parser model state and limits
    t_phase              pr_phase;
    t_sec                pr_expect;
    t_sec                pr_cur;
    logic [1:0]          pr_fcnt;
    logic [31:0]         pr_acc;
    logic [REM_W-1:0]    pr_rem;
    logic [INDEX_W-1:0]  pr_idx;
    logic [DATA_W-1:0]   pr_dsize;
    logic [BODY_W-1:0]   pr_bsum;
    logic [BODY_W-1:0]   pr_bcnt;
    logic                pr_err;
    logic [MAXC_W-1:0]   lim_code;
    logic [MAXS_W-1:0]   lim_cont;

    t_rec                records_due [$];
    logic [BYTE_W-1:0]   frame_bytes [$];
    t_script_row         script [SCRIPT_ROWS];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count = 0;
    bit                  in_quiet = 1'b0;

    eof_section_header_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_value    (i_byte_value),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_record_kind   (o_record_kind),
        .o_section_index (o_section_index),
        .o_sec_length    (o_sec_length),
        .o_status        (o_status),
        .o_last_record   (o_last_record),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one line per mismatch
    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // back to the start-of-container state
    function automatic void clear_header_state();
        pr_phase  = PH_ID;
        pr_expect = SEC_TYPE;
        pr_cur    = SEC_TERM;
        pr_fcnt   = '0;
        pr_acc    = '0;
        pr_rem    = '0;
        pr_idx    = '0;
        pr_dsize  = '0;
        pr_bsum   = '0;
        pr_bcnt   = '0;
        pr_err    = 1'b0;
    endfunction

    function automatic void push_record(input logic [KIND_W-1:0] kind,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [STATUS_W-1:0] st,
                                        input logic fin);
        t_rec rec;
        rec.kind   = kind;
        rec.index  = idx;
        rec.size   = size;
        rec.status = st;
        rec.last   = fin;
        records_due.push_back(rec);
    endfunction

    // advance the parser model by one accepted byte and queue its records
    function automatic void parse_header_byte(input logic [BYTE_W-1:0] b, input logic fin);
        t_sec                code;
        t_sec                want;
        logic [15:0]         count;
        logic [MAXC_W-1:0]   lim;
        logic [2:0]          cnt;
        logic [2:0]          width;
        logic [31:0]         val;
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  idx;
        logic [STATUS_W-1:0] st;
        logic [BODY_W:0]     hi;
        bit                  is_code;

        if (!pr_err) begin
            case (pr_phase)
                PH_ID: begin
                    case (b)
                        ID_TERM: code = SEC_TERM;
                        ID_TYPE: code = SEC_TYPE;
                        ID_CODE: code = SEC_CODE;
                        ID_CONT: code = SEC_CONT;
                        ID_DATA: code = SEC_DATA;
                        default: code = SEC_BAD;
                    endcase
                    want = pr_expect;
                    // container section is optional: fall through to data
                    if (code != want && want == SEC_CONT) begin
                        want = SEC_DATA;
                    end
                    pr_expect = want;
                    if (code != want) begin
                        pr_err = 1'b1;
                        case (want)
                            SEC_TERM: pr_acc = 32'(ST_NO_TERM);
                            SEC_TYPE: pr_acc = 32'(ST_NO_TYPE);
                            SEC_CODE: pr_acc = 32'(ST_NO_CODE);
                            default:  pr_acc = 32'(ST_NO_DATA);
                        endcase
                    end else begin
                        pr_cur  = code;
                        pr_fcnt = '0;
                        pr_acc  = '0;
                        pr_idx  = '0;
                        if (code == SEC_TERM) begin
                            pr_phase = PH_BODY;
                        end else if (code == SEC_TYPE || code == SEC_DATA) begin
                            pr_expect = (code == SEC_TYPE) ? SEC_CODE : SEC_TERM;
                            pr_rem    = 11'd1;
                            pr_phase  = PH_SIZE;
                        end else begin
                            pr_expect = (code == SEC_CODE) ? SEC_CONT : SEC_DATA;
                            pr_phase  = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    pr_acc  = {16'h0, pr_acc[7:0], b};
                    pr_fcnt = pr_fcnt + 2'd1;
                    if (pr_fcnt == 2'd2) begin
                        count   = pr_acc[15:0];
                        is_code = (pr_cur == SEC_CODE);
                        lim     = is_code ? lim_code : MAXC_W'(lim_cont);
                        if (is_code && lim > MAXC_W'(1024)) begin
                            lim = MAXC_W'(1024);
                        end
                        if (!is_code && lim > MAXC_W'(256)) begin
                            lim = MAXC_W'(256);
                        end
                        if (count == 16'd0) begin
                            pr_err = 1'b1;
                            pr_acc = 32'(ST_ZERO_SIZE);
                        end else if (count > 16'(lim)) begin
                            pr_err = 1'b1;
                            pr_acc = is_code ? 32'(ST_MANY_CODE) : 32'(ST_MANY_CONT);
                        end else begin
                            pr_rem   = count[REM_W-1:0];
                            pr_idx   = '0;
                            pr_fcnt  = '0;
                            pr_acc   = '0;
                            pr_phase = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    width   = (pr_cur == SEC_CONT) ? 3'd4 : 3'd2;
                    cnt     = {1'b0, pr_fcnt} + 3'd1;
                    pr_acc  = {pr_acc[23:0], b};
                    pr_fcnt = cnt[1:0];
                    if (cnt >= width) begin
                        val = pr_acc;
                        if (val == 32'd0 && pr_cur != SEC_DATA) begin
                            pr_err = 1'b1;
                            pr_acc = 32'(ST_ZERO_SIZE);
                        end else begin
                            idx = '0;
                            case (pr_cur)
                                SEC_TYPE: kind = KIND_TYPE;
                                SEC_CODE: begin
                                    kind = KIND_CODE;
                                    idx  = pr_idx;
                                end
                                SEC_CONT: begin
                                    kind = KIND_CONT;
                                    idx  = pr_idx;
                                end
                                default:  kind = KIND_DATA;
                            endcase
                            push_record(kind, idx, val, ST_OK, 1'b0);
                            if (pr_cur == SEC_DATA) begin
                                pr_dsize = val[15:0];
                            end else begin
                                pr_bsum = pr_bsum + BODY_W'(val);
                            end
                            pr_rem  = pr_rem - 11'd1;
                            pr_idx  = pr_idx + 10'd1;
                            pr_fcnt = '0;
                            pr_acc  = '0;
                            if (pr_rem == '0) begin
                                pr_idx   = '0;
                                pr_phase = PH_ID;
                            end
                        end
                    end
                end
                default: begin
                    // body bytes, saturating
                    if (pr_bcnt != '1) begin
                        pr_bcnt = pr_bcnt + 1'b1;
                    end
                end
            endcase
        end

        // container end: one status record
        if (fin) begin
            if (pr_err) begin
                st = pr_acc[3:0];
            end else if (pr_phase == PH_ID) begin
                st = ST_NOT_TERM;
            end else if (pr_phase == PH_COUNT) begin
                st = ST_INCOMP_NUM;
            end else if (pr_phase == PH_SIZE) begin
                st = (pr_fcnt != '0 || pr_idx != '0) ? ST_INCOMP_SIZE : ST_NOT_TERM;
            end else begin
                hi = {1'b0, pr_bsum} + (BODY_W + 1)'(pr_dsize);
                st = (pr_bcnt < pr_bsum || {1'b0, pr_bcnt} > hi) ? ST_BAD_BODY : ST_OK;
            end
            push_record(KIND_STATUS, '0, '0, st, 1'b1);
            clear_header_state();
        end
    endfunction

    // drive one byte transfer; entered and left just after a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        int r;
        gap = 0;
        if (!in_quiet) begin
            r = $urandom_range(0, 99);
            if (r < 60) gap = 0;
            else if (r < 94) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_byte_value = b;
        i_last_byte  = fin;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_header_byte(b, fin);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_bytes.size(); k++) begin
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        end
    endtask

    // apb write: setup, then access
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = addr;
        i_pwdata  = data;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (addr == ADDR_MAX_CODE) lim_code = data[MAXC_W-1:0];
        else lim_cont = data[MAXS_W-1:0];
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    // apb read and compare
    task automatic apb_read(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        i_paddr   = addr;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== want) note_mismatch("prdata", 64'(o_prdata), 64'(want));
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
    endtask

    // wait for every queued record, then let the pipeline settle
    task automatic drain_records();
        i_in_valid = 1'b0;
        while (records_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write both limits while idle and read them back
    task automatic set_limits(input logic [PDATA_W-1:0] code_v, input logic [PDATA_W-1:0] cont_v);
        drain_records();
        apb_write(ADDR_MAX_CODE, code_v);
        apb_write(ADDR_MAX_CONT, cont_v);
        apb_read(ADDR_MAX_CODE, PDATA_W'(lim_code));
        apb_read(ADDR_MAX_CONT, PDATA_W'(lim_cont));
    endtask

    function automatic logic [15:0] pick_size16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'h0000;
        if (r < 85) return 16'($urandom_range(1, 4));
        if (r < 89) return 16'hffff;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic void add16(input logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endfunction

    // random container: mostly well formed, some corrupted or cut short
    task automatic build_container();
        int          n_code;
        int          n_cont;
        int          eff_code;
        int          eff_cont;
        int          code_pos;
        int          cont_pos;
        int          body_len;
        int          room;
        int          pick;
        int          pos;
        int          r;
        longint      sum;
        logic [15:0] sz16;
        logic [15:0] dsz;
        logic [15:0] cnt_v;
        logic [31:0] sz32;

        frame_bytes.delete();
        sum      = 0;
        cont_pos = -1;
        eff_code = (lim_code > MAXC_W'(1024)) ? 1024 : int'(lim_code);
        eff_cont = (lim_cont > MAXS_W'(256)) ? 256 : int'(lim_cont);

        // type section
        frame_bytes.push_back(ID_TYPE);
        sz16 = pick_size16();
        add16(sz16);
        sum += sz16;

        // code section
        frame_bytes.push_back(ID_CODE);
        n_code = $urandom_range(1, 4);
        if (n_code > eff_code && eff_code > 0 && $urandom_range(0, 4) != 0) n_code = eff_code;
        code_pos = frame_bytes.size();
        add16(16'(n_code));
        repeat (n_code) begin
            sz16 = pick_size16();
            add16(sz16);
            sum += sz16;
        end

        // optional container section with 32-bit sizes
        if ($urandom_range(0, 1) == 1) begin
            frame_bytes.push_back(ID_CONT);
            n_cont = $urandom_range(1, 3);
            if (n_cont > eff_cont && eff_cont > 0 && $urandom_range(0, 4) != 0) n_cont = eff_cont;
            cont_pos = frame_bytes.size();
            add16(16'(n_cont));
            repeat (n_cont) begin
                r = $urandom_range(0, 99);
                if (r < 3) sz32 = 32'h0;
                else if (r < 80) sz32 = 32'($urandom_range(1, 4));
                else if (r < 85) sz32 = 32'hffff_ffff;
                else sz32 = $urandom;
                for (int k = 3; k >= 0; k--) frame_bytes.push_back(sz32[8*k +: 8]);
                sum += sz32;
            end
        end

        // data section, zero allowed
        frame_bytes.push_back(ID_DATA);
        r = $urandom_range(0, 99);
        if (r < 40) dsz = 16'h0;
        else if (r < 85) dsz = 16'($urandom_range(1, 6));
        else if (r < 92) dsz = 16'hffff;
        else dsz = 16'($urandom_range(0, 65535));
        add16(dsz);
        frame_bytes.push_back(ID_TERM);

        // body length mostly inside the allowed window
        if (sum > 48) begin
            body_len = $urandom_range(0, 6);
        end else begin
            room     = (dsz > 16) ? 16 : int'(dsz);
            body_len = int'(sum) + $urandom_range(0, room);
            pick     = $urandom_range(0, 9);
            if (pick == 0 && sum > 0) body_len = int'(sum) - 1;
            else if (pick == 1 && dsz <= 16) body_len = int'(sum) + int'(dsz) + 1;
        end
        repeat (body_len) frame_bytes.push_back(8'($urandom_range(0, 255)));

        // corruption
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                pos = $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[pos] = 8'($urandom_range(0, 255));
            end
            1: begin
                pos = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
            end
            2, 3: begin
                pos = (pick == 2 || cont_pos < 0) ? code_pos : cont_pos;
                r   = $urandom_range(0, 2);
                if (r == 0) cnt_v = 16'h0;
                else if (r == 1) cnt_v = 16'((pos == code_pos) ? eff_code + 1 : eff_cont + 1);
                else cnt_v = 16'($urandom_range(0, 65535));
                frame_bytes[pos]     = cnt_v[15:8];
                frame_bytes[pos + 1] = cnt_v[7:0];
            end
            default: ;
        endcase
    endtask

    // wide code section: 520 sizes, reaches every index bit
    task automatic build_wide_container();
        frame_bytes.delete();
        frame_bytes.push_back(ID_TYPE);
        add16(16'h0001);
        frame_bytes.push_back(ID_CODE);
        add16(16'd520);
        repeat (520) add16(16'($urandom_range(1, 65535)));
        frame_bytes.push_back(ID_DATA);
        add16(16'h0000);
        frame_bytes.push_back(ID_TERM);
    endtask

    task automatic run_random(input int target);
        int sent;
        sent = 0;
        while (sent < target) begin
            in_quiet = ($urandom_range(0, 4) == 0);
            build_container();
            send_frame();
            sent += frame_bytes.size();
        end
        in_quiet = 1'b0;
    endtask

    // record sink: random stall, compare each accepted transfer
    initial begin : record_sink
        int   stall_left;
        int   calm_left;
        int   r;
        t_rec due;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (records_due.size() == 0) begin
                    note_mismatch("unexpected record kind", 64'(o_record_kind), 64'h0);
                end else begin
                    due = records_due.pop_front();
                    if (o_record_kind !== due.kind)
                        note_mismatch("record_kind", 64'(o_record_kind), 64'(due.kind));
                    if (o_section_index !== due.index)
                        note_mismatch("section_index", 64'(o_section_index), 64'(due.index));
                    if (o_sec_length !== due.size)
                        note_mismatch("sec_length", 64'(o_sec_length), 64'(due.size));
                    if (o_status !== due.status)
                        note_mismatch("status", 64'(o_status), 64'(due.status));
                    if (o_last_record !== due.last)
                        note_mismatch("last_record", 64'(o_last_record), 64'(due.last));
                end
            end
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    calm_left   = $urandom_range(20, 100);
                    i_out_stall = 1'b0;
                end else if (r < 65) begin
                    i_out_stall = 1'b0;
                end else if (r < 95) begin
                    stall_left  = $urandom_range(0, 2);
                    i_out_stall = 1'b1;
                end else begin
                    stall_left  = $urandom_range(8, 30);
                    i_out_stall = 1'b1;
                end
            end
        end
    end

    // run-length guard
    initial begin : run_guard
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial begin : main_flow
        t_script_row row;

        lim_code = MAXC_W'(1024);
        lim_cont = MAXS_W'(256);
        clear_header_state();

        // directed bytes: bad first id, cut size, zero size, minimal good container
        script = '{
            '{8'h05,   1'b1, 1'b1, ST_NO_TYPE},
            '{ID_TYPE, 1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b1, 1'b1, ST_INCOMP_SIZE},
            '{ID_TYPE, 1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'hab,   1'b1, 1'b1, ST_ZERO_SIZE},
            '{ID_TYPE, 1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'h01,   1'b0, 1'b0, ST_OK},
            '{ID_CODE, 1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'h01,   1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'h01,   1'b0, 1'b0, ST_OK},
            '{ID_DATA, 1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b0, 1'b0, ST_OK},
            '{ID_TERM, 1'b0, 1'b0, ST_OK},
            '{8'hff,   1'b0, 1'b0, ST_OK},
            '{8'h00,   1'b1, 1'b1, ST_OK},
            '{ID_CODE, 1'b1, 1'b1, ST_NO_TYPE},
            '{ID_TYPE, 1'b1, 1'b1, ST_NOT_TERM}
        };

        // reset
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // limits come up at their reset values
        apb_read(ADDR_MAX_CODE, PDATA_W'(1024));
        apb_read(ADDR_MAX_CONT, PDATA_W'(256));

        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            row = script[k];
            send_byte(row.value, row.fin);
            if (row.typed) begin
                if (records_due.size() == 0 || records_due[$].last !== 1'b1)
                    note_mismatch("model status record", 64'h0, 64'h1);
                else if (records_due[$].status !== row.status)
                    note_mismatch("model status", 64'(records_due[$].status), 64'(row.status));
            end
        end

        // reset limits, then a sweep of settings
        run_random(100);
        build_wide_container();
        send_frame();

        set_limits(32'hffff_ffff, 32'hffff_ffff);
        run_random(90);
        set_limits(32'h0, 32'h0);
        run_random(90);
        set_limits(32'd1, 32'd1);
        run_random(90);
        set_limits(PDATA_W'($urandom_range(1, 6)), PDATA_W'($urandom_range(1, 4)));
        run_random(90);
        set_limits(32'd1024, 32'd256);
        run_random(90);

        drain_records();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
